// ===== rtl/core/ddw_pkg.sv =====
`timescale 1ns / 1ps

package ddw_pkg;

  localparam int DataW = 32;
  localparam int NumRegs = 7;
  localparam int RegIdxW = 3;
  localparam int DtW = 16;

  localparam logic signed [31:0] DeadTorque = 32'sd4588;
  localparam logic signed [31:0] DeadSpeed = 32'sd13107;
  localparam logic signed [31:0] QOne = 32'sh0001_0000;
  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  localparam logic [1:0] KindLeft = 2'd0;
  localparam logic [1:0] KindRight = 2'd1;
  localparam logic [1:0] KindTick = 2'd2;
  localparam logic [1:0] KindSpare = 2'd3;

  localparam logic [2:0] RegInvDiag = 3'd0;
  localparam logic [2:0] RegInvCross = 3'd1;
  localparam logic [2:0] RegCoriolis = 3'd2;
  localparam logic [2:0] RegStatic = 3'd3;
  localparam logic [2:0] RegViscous = 3'd4;
  localparam logic [2:0] RegHalfRad = 3'd5;
  localparam logic [2:0] RegRadTrack = 3'd6;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] torque_value;
    logic [15:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] right_wheel_speed;
    logic signed [31:0] left_wheel_speed;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
  } out_item_t;

  // alu operations
  typedef enum logic [1:0] {
    OpMul = 2'd0,
    OpAdd = 2'd1,
    OpSub = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_req_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7fff_ffff) return QMax;
    if (v < -33'sh0_8000_0000) return QMin;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/ddw_alu.sv =====
`timescale 1ns / 1ps

module ddw_alu (
  input  ddw_pkg::alu_req_t   req,
  output logic signed [31:0]  res
);

  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  logic signed [47:0] shf;
  logic signed [32:0] sum;

  always_comb begin
    prod = req.a * req.b;
    rnd = prod + 64'sd32768;
    // arithmetic shift floors, so with the added half it rounds to nearest, ties up
    shf = rnd[63:16];
    sum = 33'sd0;
    res = 32'sd0;
    unique case (req.op)
      ddw_pkg::OpMul: begin
        if (shf > 48'sh0000_7fff_ffff) res = ddw_pkg::QMax;
        else if (shf < -48'sh0000_8000_0000) res = ddw_pkg::QMin;
        else res = shf[31:0];
      end
      ddw_pkg::OpAdd: begin
        sum = {req.a[31], req.a} + {req.b[31], req.b};
        res = ddw_pkg::sat33(sum);
      end
      ddw_pkg::OpSub: begin
        sum = {req.a[31], req.a} - {req.b[31], req.b};
        res = ddw_pkg::sat33(sum);
      end
      default: res = 32'sd0;
    endcase
  end

endmodule

// ===== rtl/core/diff_drive_wheel_dynamics_step.sv =====
`timescale 1ns / 1ps
// a torque beat is stored when taken; a tick beat runs the step schedule and then gives its result beat
// on one shared 32x32 q16.16 saturating multiply/add/sub unit, one op per cycle,
// under a 29-step counter; the block takes no beat while a tick is running
// or its result waits. sync reset clears config regs, wheel state, step state and output valid
module diff_drive_wheel_dynamics_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ddw_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ddw_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [ddw_pkg::RegIdxW-1:0]   cfg_index,
  input  logic [ddw_pkg::DataW-1:0]     cfg_data
);

  logic signed [31:0] regs [ddw_pkg::NumRegs];
  logic signed [31:0] r_spd, l_spd, r_trq, l_trq, yaw;
  logic signed [31:0] t0, t1, t2, t3;
  logic [ddw_pkg::DtW-1:0] dt;
  logic busy;
  logic [4:0] step;
  ddw_pkg::alu_req_t req;
  logic signed [31:0] res;

  localparam logic [4:0] LastStep = 5'd28;

  ddw_alu u_alu (.req(req), .res(res));

  function automatic logic signed [31:0] sgn(input logic signed [31:0] v);
    if (v > 0) return ddw_pkg::QOne;
    if (v < 0) return -ddw_pkg::QOne;
    return 32'sd0;
  endfunction

  function automatic logic light(input logic signed [31:0] v);
    logic [32:0] m;
    m = v[31] ? -{1'b1, v} : {1'b0, v};
    return m < 33'd4588;
  endfunction

  function automatic logic slow(input logic signed [31:0] v);
    logic [32:0] m;
    m = v[31] ? -{1'b1, v} : {1'b0, v};
    return m < 33'd13107;
  endfunction

  assign in_ready = !busy && !out_valid;

  // step schedule, t0..t3 scratch
  always_comb begin
    req = '{op: ddw_pkg::OpMul, a: 32'sd0, b: 32'sd0};
    case (step)
      5'd0:  req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegStatic], sgn(r_spd)};
      5'd1:  req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegViscous], r_spd};
      5'd2:  req = '{ddw_pkg::OpAdd, t0, t1};            // fr_r
      5'd3:  req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegStatic], sgn(l_spd)};
      5'd4:  req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegViscous], l_spd};
      5'd5:  req = '{ddw_pkg::OpAdd, t1, t2};            // fr_l -> t1
      5'd6:  req = '{ddw_pkg::OpMul, yaw, regs[ddw_pkg::RegCoriolis]};
      5'd7:  req = '{ddw_pkg::OpMul, t2, l_spd};
      5'd8:  req = '{ddw_pkg::OpSub, r_trq, t2};
      5'd9:  req = '{ddw_pkg::OpSub, t2, t0};            // force_r -> t0
      5'd10: req = '{ddw_pkg::OpSub, 32'sd0, regs[ddw_pkg::RegCoriolis]};
      5'd11: req = '{ddw_pkg::OpMul, yaw, t2};
      5'd12: req = '{ddw_pkg::OpMul, t2, r_spd};
      5'd13: req = '{ddw_pkg::OpSub, l_trq, t2};
      5'd14: req = '{ddw_pkg::OpSub, t2, t1};            // force_l -> t1
      5'd15: req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegInvDiag], t0};
      5'd16: req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegInvCross], t1};
      5'd17: req = '{ddw_pkg::OpAdd, t2, t3};            // acc_r -> t2
      5'd18: req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegInvCross], t0};
      5'd19: req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegInvDiag], t1};
      5'd20: req = '{ddw_pkg::OpAdd, t3, t0};            // acc_l -> t3
      5'd21: req = '{ddw_pkg::OpMul, t2, {16'd0, dt}};
      5'd22: req = '{ddw_pkg::OpMul, t3, {16'd0, dt}};
      5'd23: req = '{ddw_pkg::OpAdd, r_spd, t2};
      5'd24: req = '{ddw_pkg::OpAdd, l_spd, t3};
      5'd25: req = '{ddw_pkg::OpAdd, r_spd, l_spd};
      5'd26: req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegHalfRad], t0};
      5'd27: req = '{ddw_pkg::OpSub, r_spd, l_spd};
      5'd28: req = '{ddw_pkg::OpMul, regs[ddw_pkg::RegRadTrack], t0};
      default: req = '{ddw_pkg::OpMul, 32'sd0, 32'sd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ddw_pkg::NumRegs; i++) regs[i] <= 32'sd0;
      r_spd <= 32'sd0;
      l_spd <= 32'sd0;
      r_trq <= 32'sd0;
      l_trq <= 32'sd0;
      yaw <= 32'sd0;
      busy <= 1'b0;
      step <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index < 3'(ddw_pkg::NumRegs)) regs[cfg_index] <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_valid && in_ready) begin
        unique case (in_data.kind)
          ddw_pkg::KindLeft:
            l_trq <= (light(in_data.torque_value) && slow(l_spd)) ? 32'sd0
                     : in_data.torque_value;
          ddw_pkg::KindRight:
            r_trq <= (light(in_data.torque_value) && slow(r_spd)) ? 32'sd0
                     : in_data.torque_value;
          ddw_pkg::KindTick: begin
            busy <= 1'b1;
            step <= 5'd0;
            dt <= in_data.time_step;
          end
          default: ;
        endcase
      end
      if (busy) begin
        case (step)
          5'd0, 5'd2, 5'd9, 5'd19, 5'd25, 5'd27: t0 <= res;
          5'd1, 5'd4, 5'd5, 5'd14:               t1 <= res;
          5'd3, 5'd6, 5'd7, 5'd8, 5'd10, 5'd11, 5'd12, 5'd13, 5'd15, 5'd17, 5'd21:
                                                 t2 <= res;
          5'd16, 5'd18, 5'd20, 5'd22:            t3 <= res;
          5'd23:                                 r_spd <= res;
          5'd24:                                 l_spd <= res;
          5'd26:                                 out_data.linear_velocity <= res;
          5'd28: begin
            yaw <= res;
            out_data.angular_velocity <= res;
            out_data.right_wheel_speed <= r_spd;
            out_data.left_wheel_speed <= l_spd;
          end
          default: ;
        endcase
        if (step == LastStep) begin
          out_valid <= 1'b1;
          busy <= 1'b0;
        end else begin
          step <= step + 5'd1;
        end
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("ready while busy");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    !(busy && out_valid)) else $error("busy with result pending");

endmodule
